[design/atgt_pkg.sv]
// Shared constants and types for the text grid terminal.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package atgt_pkg;
	localparam int GridCols = 80;
	localparam int GridRows = 30;
	localparam int CellCount = GridCols * GridRows;
	localparam int AddrW = $clog2(CellCount);
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChDel = 8'h7F;
	localparam logic [7:0] ChEsc = 8'h1B;
	localparam logic [7:0] ChBell = 8'h07;
	localparam logic [7:0] ChLf = 8'h0A;
	localparam logic [7:0] ChCr = 8'h0D;
	localparam logic [7:0] ChBs = 8'h08;
	localparam logic [7:0] ChLbr = 8'h5B;
	localparam logic [7:0] ChSemi = 8'h3B;
	localparam logic [7:0] ChK = 8'h4B;
	localparam logic [7:0] ChC = 8'h43;
	localparam logic [7:0] ChD = 8'h44;
	localparam logic [7:0] ChH = 8'h48;
	localparam logic [7:0] ChJ = 8'h4A;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_READ,     // start a read of the addressed cell
		OP_WRITE,    // write wdata at the address
		OP_COPY_RD,  // read source cell of a scroll copy
		OP_COPY_WR   // write the previously read cell at the address
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [AddrW-1:0] addr;
		logic [7:0] wdata;
	} dp_cmd_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic clr_done;
	} dp_stat_t;
endpackage
`default_nettype wire

[design/ansi_text_grid_terminal_unit.sv]
// Top level of the text grid terminal: controller plus screen datapath.
// Depends on atgt_pkg, atgt_controller and atgt_datapath.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy low; its one result appears
// for a single cycle with strobe high and cannot be stalled. After reset the
// screen memory is swept to spaces with busy high. Reads, plain bytes, erases,
// scrolls (a copy of each cell one row up, then a fill of the new bottom row)
// and clear screen all go through the one memory port.
module ansi_text_grid_terminal_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic mode,
	input wire logic [7:0] data_byte,
	input wire logic [4:0] read_row,
	input wire logic [6:0] read_col,
	output logic strobe,
	output logic [7:0] cell_char,
	output logic [4:0] cursor_row_out,
	output logic [6:0] cursor_col_out,
	output logic [1:0] parse_state
);
	atgt_pkg::dp_cmd_t cmd;
	atgt_pkg::dp_stat_t stat;

	atgt_controller u_ctrl (
		.clk, .arst_n, .start, .busy, .mode, .data_byte, .read_row, .read_col,
		.strobe, .cell_char, .cursor_row_out, .cursor_col_out, .parse_state,
		.cmd, .stat
	);

	atgt_datapath u_dp (.clk, .arst_n, .cmd, .stat);
endmodule
`default_nettype wire

[design/atgt_datapath.sv]
// Screen memory datapath: one-port cell store, registered read, and
// the clearing pass after reset. Depends on atgt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module atgt_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire atgt_pkg::dp_cmd_t cmd,
	output atgt_pkg::dp_stat_t stat
);
	logic [7:0] mem [atgt_pkg::CellCount];
	logic [7:0] rdata_q;
	logic [atgt_pkg::AddrW-1:0] clr_addr_q;
	logic clr_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			if (clr_addr_q == atgt_pkg::AddrW'(atgt_pkg::CellCount - 1))
				clr_done_q <= 1'b1;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_done_q) begin
			mem[clr_addr_q] <= atgt_pkg::ChSpace;
		end else if (cmd.op == atgt_pkg::OP_WRITE) begin
			mem[cmd.addr] <= cmd.wdata;
		end else if (cmd.op == atgt_pkg::OP_COPY_WR) begin
			mem[cmd.addr] <= rdata_q;
		end
		if (cmd.op == atgt_pkg::OP_READ || cmd.op == atgt_pkg::OP_COPY_RD)
			rdata_q <= mem[cmd.addr];
	end

	assign stat.rdata = rdata_q;
	assign stat.clr_done = clr_done_q;
endmodule
`default_nettype wire

[design/atgt_controller.sv]
// Controller: escape parser, cursor, and sequencer of grid passes.
// Drives atgt_datapath by commands; depends on atgt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module atgt_controller (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic mode,
	input wire logic [7:0] data_byte,
	input wire logic [4:0] read_row,
	input wire logic [6:0] read_col,
	output logic strobe,
	output logic [7:0] cell_char,
	output logic [4:0] cursor_row_out,
	output logic [6:0] cursor_col_out,
	output logic [1:0] parse_state,
	output atgt_pkg::dp_cmd_t cmd,
	input wire atgt_pkg::dp_stat_t stat
);
	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DECODE, S_RD_WAIT, S_RD_DONE,
		S_SCR_RD, S_SCR_WR, S_FILL, S_DONE
	} state_t;

	localparam int AW = atgt_pkg::AddrW;
	localparam logic [AW-1:0] LastRowBase =
		AW'((atgt_pkg::GridRows - 1) * atgt_pkg::GridCols);

	state_t state_q;
	logic [7:0] byte_q;
	logic [4:0] rrow_q;
	logic [6:0] rcol_q;
	logic [4:0] row_q;
	logic [6:0] col_q;
	logic [1:0] esc_q;
	logic [7:0] arg0_q, arg1_q;
	logic [1:0] aidx_q;
	logic [AW-1:0] ptr_q, end_q;
	logic [AW-1:0] row_base;
	logic [AW-1:0] rd_addr;
	logic [7:0] narg;
	logic [11:0] acc_mul;
	logic [7:0] cur_arg;
	logic [3:0] digit;
	logic [8:0] col_sum;
	// Low while a printable byte still has to be stored; the first fill cycle
	// of such a request carries the byte, every other fill cycle writes a space.
	logic blank_q;

	assign row_base = AW'(row_q * atgt_pkg::GridCols);
	assign rd_addr = AW'(rrow_q * atgt_pkg::GridCols) + AW'(rcol_q);
	assign narg = (arg0_q == 8'd0) ? 8'd1 : arg0_q;
	assign cur_arg = aidx_q[0] ? arg1_q : arg0_q;
	assign digit = 4'(byte_q - 8'h30);
	assign acc_mul = 12'(cur_arg) * 12'd10 + 12'(digit);
	assign col_sum = 9'(col_q) + 9'(narg);
	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '{op: atgt_pkg::OP_NONE, addr: ptr_q, wdata: atgt_pkg::ChSpace};
		case (state_q)
			S_RD_WAIT: begin
				cmd.op = atgt_pkg::OP_READ;
				cmd.addr = rd_addr;
			end
			S_SCR_RD: begin
				cmd.op = atgt_pkg::OP_COPY_RD;
				cmd.addr = ptr_q + AW'(atgt_pkg::GridCols);
			end
			S_SCR_WR: cmd.op = atgt_pkg::OP_COPY_WR;
			S_FILL: begin
				cmd.op = atgt_pkg::OP_WRITE;
				if (!blank_q) cmd.wdata = byte_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			byte_q <= '0;
			rrow_q <= '0;
			rcol_q <= '0;
			row_q <= '0;
			col_q <= '0;
			esc_q <= '0;
			arg0_q <= '0;
			arg1_q <= '0;
			aidx_q <= '0;
			strobe <= 1'b0;
			cell_char <= '0;
			ptr_q <= '0;
			end_q <= '0;
			blank_q <= 1'b1;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_INIT: if (stat.clr_done) state_q <= S_IDLE;
				S_IDLE: if (start) begin
					byte_q <= data_byte;
					rrow_q <= read_row;
					rcol_q <= read_col;
					cell_char <= '0;
					state_q <= mode ? S_RD_WAIT : S_DECODE;
				end
				S_RD_WAIT: begin
					if (rrow_q < 5'(atgt_pkg::GridRows) && rcol_q < 7'(atgt_pkg::GridCols))
						state_q <= S_RD_DONE;
					else
						state_q <= S_DONE;
				end
				S_RD_DONE: begin
					cell_char <= stat.rdata;
					state_q <= S_DONE;
				end
				S_DECODE: begin
					state_q <= S_DONE;
					blank_q <= !(esc_q == 2'd0 && byte_q >= atgt_pkg::ChSpace &&
						byte_q < atgt_pkg::ChDel);
					if (esc_q == 2'd0) begin
						if (byte_q == atgt_pkg::ChLf) begin
							col_q <= '0;
							if (row_q == 5'(atgt_pkg::GridRows - 1)) begin
								ptr_q <= '0;
								state_q <= S_SCR_RD;
							end else row_q <= row_q + 1'b1;
						end else if (byte_q == atgt_pkg::ChCr) begin
							col_q <= '0;
						end else if (byte_q == atgt_pkg::ChBs || byte_q == atgt_pkg::ChDel) begin
							// Erase the cell at the new cursor position.
							ptr_q <= row_base + AW'(col_q == 7'd0 ? 7'd0 : col_q - 1'b1);
							end_q <= row_base + AW'(col_q == 7'd0 ? 7'd0 : col_q - 1'b1);
							state_q <= S_FILL;
							if (col_q != 7'd0) col_q <= col_q - 1'b1;
						end else if (byte_q == atgt_pkg::ChEsc) begin
							esc_q <= 2'd1;
						end else if (byte_q >= atgt_pkg::ChSpace && byte_q < atgt_pkg::ChDel) begin
							if (col_q == 7'(atgt_pkg::GridCols)) begin
								col_q <= 7'd1;
								if (row_q == 5'(atgt_pkg::GridRows - 1)) begin
									// Scroll first, then the fill pass stores the byte.
									ptr_q <= '0;
									state_q <= S_SCR_RD;
								end else begin
									row_q <= row_q + 1'b1;
									ptr_q <= row_base + AW'(atgt_pkg::GridCols);
									end_q <= row_base + AW'(atgt_pkg::GridCols);
									state_q <= S_FILL;
								end
							end else begin
								ptr_q <= row_base + AW'(col_q);
								end_q <= row_base + AW'(col_q);
								col_q <= col_q + 1'b1;
								state_q <= S_FILL;
							end
						end
					end else if (esc_q == 2'd1) begin
						if (byte_q == atgt_pkg::ChLbr) begin
							esc_q <= 2'd2;
							aidx_q <= '0;
							arg0_q <= '0;
							arg1_q <= '0;
						end else esc_q <= 2'd0;
					end else begin
						if (byte_q >= 8'h30 && byte_q <= 8'h39) begin
							if (!aidx_q[1]) begin
								if (aidx_q[0])
									arg1_q <= (acc_mul > 12'd255) ? 8'd255 : acc_mul[7:0];
								else
									arg0_q <= (acc_mul > 12'd255) ? 8'd255 : acc_mul[7:0];
							end
						end else if (byte_q == atgt_pkg::ChSemi) begin
							if (aidx_q != 2'd3) aidx_q <= aidx_q + 1'b1;
						end else begin
							esc_q <= 2'd0;
							case (byte_q)
								atgt_pkg::ChK: begin
									if (arg0_q == 8'd2) begin
										ptr_q <= row_base;
										end_q <= row_base + AW'(atgt_pkg::GridCols - 1);
										state_q <= S_FILL;
									end else if (col_q < 7'(atgt_pkg::GridCols)) begin
										ptr_q <= row_base + AW'(col_q);
										end_q <= row_base + AW'(atgt_pkg::GridCols - 1);
										state_q <= S_FILL;
									end
								end
								atgt_pkg::ChD: col_q <= (8'(col_q) > narg) ? 7'(8'(col_q) - narg) : 7'd0;
								atgt_pkg::ChC: col_q <= (col_sum >= 9'(atgt_pkg::GridCols)) ?
									7'(atgt_pkg::GridCols - 1) : col_sum[6:0];
								atgt_pkg::ChH: begin
									row_q <= (arg0_q == 8'd0) ? 5'd0 :
										(arg0_q - 8'd1 >= 8'(atgt_pkg::GridRows)) ?
										5'(atgt_pkg::GridRows - 1) : 5'(arg0_q - 8'd1);
									col_q <= (arg1_q == 8'd0) ? 7'd0 :
										(arg1_q - 8'd1 >= 8'(atgt_pkg::GridCols)) ?
										7'(atgt_pkg::GridCols - 1) : 7'(arg1_q - 8'd1);
								end
								atgt_pkg::ChJ: if (arg0_q == 8'd2) begin
									row_q <= '0;
									col_q <= '0;
									ptr_q <= '0;
									end_q <= AW'(atgt_pkg::CellCount - 1);
									state_q <= S_FILL;
								end
								default: ;
							endcase
						end
					end
				end
				S_SCR_RD: state_q <= S_SCR_WR;
				S_SCR_WR: begin
					if (ptr_q == LastRowBase - 1'b1) begin
						ptr_q <= LastRowBase;
						end_q <= LastRowBase + AW'(atgt_pkg::GridCols - 1);
						state_q <= S_FILL;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						state_q <= S_SCR_RD;
					end
				end
				S_FILL: begin
					blank_q <= 1'b1;
					if (ptr_q == end_q) state_q <= S_DONE;
					else ptr_q <= ptr_q + 1'b1;
				end
				S_DONE: begin
					strobe <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cursor_row_out = row_q;
	assign cursor_col_out = col_q;
	assign parse_state = esc_q;
endmodule
`default_nettype wire

[verif/tb_ansi_text_grid_terminal_unit.sv]
// Testbench for the text grid terminal: drives write and read requests, predicts
// every result with a model of the grid, cursor and escape parser. Depends on atgt_pkg.
`timescale 1ns / 1ps
module tb_ansi_text_grid_terminal_unit;
	typedef struct packed {
		logic mode;
		logic [7:0] data_byte;
		logic [4:0] read_row;
		logic [6:0] read_col;
		logic hold; // wait until all results are in before this request
	} req_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [4:0] row;
		logic [6:0] col;
		logic [1:0] pstate;
	} term_result_t;

	typedef enum logic [1:0] {PS_NORMAL, PS_ESC, PS_CSI} parse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic mode = 1'b0;
	logic [7:0] data_byte = '0;
	logic [4:0] read_row = '0;
	logic [6:0] read_col = '0;
	logic busy, strobe;
	logic [7:0] cell_char;
	logic [4:0] cursor_row_out;
	logic [6:0] cursor_col_out;
	logic [1:0] parse_state;

	req_t pending_reqs[$];
	term_result_t expected_results[$];
	int errors = 0;
	bit stim_done = 1'b0;

	// Predictor state.
	logic [7:0] grid [atgt_pkg::GridRows][atgt_pkg::GridCols];
	int cur_row, cur_col, arg_idx;
	int args [2];
	parse_t pstate;

	ansi_text_grid_terminal_unit u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void clear_grid();
		foreach (grid[r, c]) grid[r][c] = atgt_pkg::ChSpace;
	endfunction

	function automatic void next_line();
		cur_col = 0;
		cur_row++;
		if (cur_row >= atgt_pkg::GridRows) begin
			for (int r = 0; r < atgt_pkg::GridRows - 1; r++) grid[r] = grid[r + 1];
			for (int c = 0; c < atgt_pkg::GridCols; c++)
				grid[atgt_pkg::GridRows - 1][c] = atgt_pkg::ChSpace;
			cur_row = atgt_pkg::GridRows - 1;
		end
	endfunction

	function automatic void csi_final(logic [7:0] ch);
		int n, r, c;
		n = (args[0] == 0) ? 1 : args[0];
		case (ch)
			atgt_pkg::ChK: begin
				if (args[0] == 2) begin
					for (c = 0; c < atgt_pkg::GridCols; c++) grid[cur_row][c] = atgt_pkg::ChSpace;
				end else if (cur_col < atgt_pkg::GridCols) begin
					for (c = cur_col; c < atgt_pkg::GridCols; c++)
						grid[cur_row][c] = atgt_pkg::ChSpace;
				end
			end
			atgt_pkg::ChD: cur_col = (cur_col > n) ? cur_col - n : 0;
			atgt_pkg::ChC: begin
				cur_col += n;
				if (cur_col >= atgt_pkg::GridCols) cur_col = atgt_pkg::GridCols - 1;
			end
			atgt_pkg::ChH: begin
				r = (args[0] > 0) ? args[0] - 1 : 0;
				c = (args[1] > 0) ? args[1] - 1 : 0;
				cur_row = (r >= atgt_pkg::GridRows) ? atgt_pkg::GridRows - 1 : r;
				cur_col = (c >= atgt_pkg::GridCols) ? atgt_pkg::GridCols - 1 : c;
			end
			atgt_pkg::ChJ: begin
				if (args[0] == 2) begin
					clear_grid();
					cur_row = 0;
					cur_col = 0;
				end
			end
			default: ;
		endcase
		pstate = PS_NORMAL;
	endfunction

	function automatic void feed_terminal(logic [7:0] ch);
		int v;
		case (pstate)
			PS_NORMAL: begin
				if (ch == atgt_pkg::ChLf) next_line();
				else if (ch == atgt_pkg::ChCr) cur_col = 0;
				else if (ch == atgt_pkg::ChBs || ch == atgt_pkg::ChDel) begin
					if (cur_col > 0) cur_col--;
					if (cur_col < atgt_pkg::GridCols) grid[cur_row][cur_col] = atgt_pkg::ChSpace;
				end else if (ch == atgt_pkg::ChEsc) pstate = PS_ESC;
				else if (ch >= atgt_pkg::ChSpace && ch < atgt_pkg::ChDel) begin
					if (cur_col >= atgt_pkg::GridCols) next_line();
					grid[cur_row][cur_col] = ch;
					cur_col++;
				end
			end
			PS_ESC: begin
				if (ch == atgt_pkg::ChLbr) begin
					pstate = PS_CSI;
					arg_idx = 0;
					args[0] = 0;
					args[1] = 0;
				end else pstate = PS_NORMAL;
			end
			default: begin
				if (ch >= "0" && ch <= "9") begin
					if (arg_idx < 2) begin
						v = args[arg_idx] * 10 + (ch - "0");
						args[arg_idx] = (v > 255) ? 255 : v;
					end
				end else if (ch == atgt_pkg::ChSemi) begin
					if (arg_idx < 3) arg_idx++;
				end else csi_final(ch);
			end
		endcase
	endfunction

	function automatic term_result_t predict_terminal(req_t q);
		term_result_t res;
		res.cell_char = '0;
		if (!q.mode) feed_terminal(q.data_byte);
		else if (q.read_row < atgt_pkg::GridRows && q.read_col < atgt_pkg::GridCols)
			res.cell_char = grid[q.read_row][q.read_col];
		res.row = cur_row[4:0];
		res.col = cur_col[6:0];
		res.pstate = pstate;
		return res;
	endfunction

	// Driver: one request at a time, random gap before each.
	int gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(predict_terminal(pending_reqs.pop_front()));
				start <= 1'b0;
				gap = $urandom_range(0, 3);
			end else if (!start && pending_reqs.size() > 0) begin
				if (gap > 0) gap--;
				else if (!pending_reqs[0].hold || expected_results.size() == 0) begin
					mode <= pending_reqs[0].mode;
					data_byte <= pending_reqs[0].data_byte;
					read_row <= pending_reqs[0].read_row;
					read_col <= pending_reqs[0].read_col;
					start <= 1'b1;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		term_result_t exp_r;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (cell_char !== exp_r.cell_char) begin
					$error("cell_char exp %0h got %0h", exp_r.cell_char, cell_char);
					errors++;
				end
				if (cursor_row_out !== exp_r.row) begin
					$error("cursor_row_out exp %0d got %0d", exp_r.row, cursor_row_out);
					errors++;
				end
				if (cursor_col_out !== exp_r.col) begin
					$error("cursor_col_out exp %0d got %0d", exp_r.col, cursor_col_out);
					errors++;
				end
				if (parse_state !== exp_r.pstate) begin
					$error("parse_state exp %0d got %0d", exp_r.pstate, parse_state);
					errors++;
				end
			end
		end
	end

	function automatic void add_byte(logic [7:0] b);
		req_t q;
		q.mode = 1'b0;
		q.data_byte = b;
		q.read_row = 5'($urandom);
		q.read_col = 7'($urandom);
		q.hold = 1'b0;
		pending_reqs.push_back(q);
	endfunction

	function automatic void add_read(logic [4:0] r, logic [6:0] c);
		req_t q;
		q.mode = 1'b1;
		q.data_byte = 8'($urandom);
		q.read_row = r;
		q.read_col = c;
		q.hold = 1'b0;
		pending_reqs.push_back(q);
	endfunction

	function automatic void add_csi(int a0, int a1, logic [7:0] fin);
		string s;
		add_byte(atgt_pkg::ChEsc);
		add_byte(atgt_pkg::ChLbr);
		if (a0 >= 0) begin
			s = $sformatf("%0d", a0);
			foreach (s[i]) add_byte(s[i]);
		end
		if (a1 >= 0) begin
			add_byte(atgt_pkg::ChSemi);
			s = $sformatf("%0d", a1);
			foreach (s[i]) add_byte(s[i]);
		end
		add_byte(fin);
	endfunction

	function automatic logic [7:0] printable();
		return 8'($urandom_range(32'h20, 32'h7E));
	endfunction

	int count_items;
	initial begin
		logic [7:0] finals [6];
		int k;
		finals = '{atgt_pkg::ChK, atgt_pkg::ChC, atgt_pkg::ChD, atgt_pkg::ChH,
			atgt_pkg::ChJ, "m"};
		clear_grid();
		cur_row = 0;
		cur_col = 0;
		arg_idx = 0;
		args = '{0, 0};
		pstate = PS_NORMAL;

		// Directed part.
		add_read(0, 0);
		add_read(29, 79);
		add_read(31, 127);
		add_byte("A");
		add_byte(8'hFF);
		add_byte(atgt_pkg::ChBell);
		add_byte(atgt_pkg::ChBs);
		add_byte(atgt_pkg::ChDel);
		add_csi(300, 999, atgt_pkg::ChH);
		add_byte("Z");
		add_byte("Q");
		add_byte(atgt_pkg::ChCr);
		add_byte(atgt_pkg::ChLf);
		add_csi(2, -1, atgt_pkg::ChK);
		add_csi(-1, -1, atgt_pkg::ChC);
		add_byte(atgt_pkg::ChEsc);
		add_byte("x");
		add_csi(5, 9, atgt_pkg::ChD);
		add_csi(2, -1, atgt_pkg::ChJ);
		pending_reqs[$].hold = 1'b1;
		add_read(0, 1);

		count_items = pending_reqs.size();
		while (count_items < 850) begin
			k = $urandom_range(0, 99);
			if (k < 40) add_byte(printable());
			else if (k < 50) add_byte(atgt_pkg::ChLf);
			else if (k < 55) add_byte(8'($urandom));
			else if (k < 60) add_byte(k[0] ? atgt_pkg::ChBs : atgt_pkg::ChDel);
			else if (k < 63) add_byte(atgt_pkg::ChCr);
			else if (k < 80) add_read(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
			else if (k < 95)
				add_csi($urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, 40),
					$urandom_range(0, 2) == 0 ? -1 : $urandom_range(0, 90),
					($urandom_range(0, 30) == 0) ? atgt_pkg::ChJ : finals[$urandom_range(0, 5)]);
			else begin
				// Broken sequences.
				add_byte(atgt_pkg::ChEsc);
				if (k[0]) add_byte(atgt_pkg::ChLbr);
				add_byte(8'($urandom));
			end
			if ($urandom_range(0, 199) == 0) pending_reqs[$].hold = 1'b1;
			count_items = pending_reqs.size();
		end
		pending_reqs[400].hold = 1'b1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0 && !start);
		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
